// ===== design/assert_macros.svh =====
// Assertion macros for the checker file ptc_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types and constants of the paragraph-aware text chunker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

    localparam int unsigned MAX_WINDOW = 4096;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_OVERLAP   = 2'd1;
    localparam logic [1:0] REG_PARAGRAPH = 2'd2;
    localparam logic [1:0] REG_FIRSTLINE = 2'd3;

    localparam logic [12:0] WINDOW_RESET    = 13'd512;
    localparam logic [12:0] OVERLAP_RESET   = 13'd64;
    localparam logic        PARAGRAPH_RESET = 1'b1;
    localparam logic [31:0] FIRSTLINE_RESET = 32'd1;

    // Chunk descriptor before the start line is known
    typedef struct packed {
        logic [31:0] start;
        logic [12:0] length;
        logic        fin;
        logic        last;
    } desc_t;

    // Complete result item
    typedef struct packed {
        logic [31:0] start;
        logic [12:0] length;
        logic [31:0] line;
        logic        fin;
        logic        last;
    } result_t;

    // What the tracker decides for one accepted byte
    typedef struct packed {
        logic [1:0]  count;
        desc_t       desc0;
        desc_t       desc1;
        logic        fwd0;
        logic        fwd1;
        logic [31:0] fwd_line;
    } plan_t;

endpackage

`default_nettype wire

// ===== design/paragraph_aware_text_chunker.sv =====
// A byte's first result can transfer once it has passed the RAM read and the result queue write.
// Throughput: one byte per cycle while s_axis_tready is high; state updates once per byte.
// A byte that ends one chunk and flushes the tail yields two results; the output side then
// gives them out one at a time and the 4-entry result queue throttles the input.
// Reset: aresetn is synchronous, active low; it clears document state, the queue and loads
// register defaults. The line RAM is not cleared: entries are written before they are read.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// paragraph_aware_text_chunker
// Splits a byte stream into overlapping chunks, preferring blank-line splits.
// ----------------------------------------------------------------------------
module paragraph_aware_text_chunker #(
    parameter int unsigned WINDOW_DEPTH     = 8192,
    parameter int unsigned MIN_SPLIT_OFFSET = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_document
    // chunk descriptors
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [79:0] m_axis_tdata,   // [31:0] chunk_start, [44:32] chunk_length,
                                             // [76:45] chunk_line, [79:77] zero
    output logic      [0:0]  m_axis_tuser,   // [0] final_chunk
    output logic             m_axis_tlast    // run_last
);

    localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);

    logic [12:0] window_reg;
    logic [12:0] overlap_reg;
    logic        paragraph_reg;
    logic [31:0] first_line_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= ptc_pkg::WINDOW_RESET;
            overlap_reg    <= ptc_pkg::OVERLAP_RESET;
            paragraph_reg  <= ptc_pkg::PARAGRAPH_RESET;
            first_line_reg <= ptc_pkg::FIRSTLINE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ptc_pkg::REG_WINDOW:    window_reg     <= cfg_wdata[12:0];
                ptc_pkg::REG_OVERLAP:   overlap_reg    <= cfg_wdata[12:0];
                ptc_pkg::REG_PARAGRAPH: paragraph_reg  <= cfg_wdata[0];
                ptc_pkg::REG_FIRSTLINE: first_line_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic              accept;
    ptc_pkg::plan_t    plan;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [31:0]       rd_data0;
    logic [31:0]       rd_data1;

    assign accept = s_axis_tvalid && s_axis_tready;

    ptc_tracker #(
        .DEPTH     (WINDOW_DEPTH),
        .ADDR_W    (ADDR_W),
        .MIN_SPLIT (MIN_SPLIT_OFFSET)
    ) u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .data_byte       (s_axis_tdata),
        .end_of_document (s_axis_tlast),
        .window_bytes    (window_reg),
        .overlap_bytes   (overlap_reg),
        .paragraph_mode  (paragraph_reg),
        .plan            (plan),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_addr0        (rd_addr0),
        .rd_addr1        (rd_addr1)
    );

    ptc_line_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .aclk     (aclk),
        .wr_en    (accept),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (accept),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    // Stage holding the plan while the RAM read completes
    logic [1:0]     s1_count_reg;
    ptc_pkg::plan_t s1_plan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_count_reg <= '0;
        end else begin
            s1_count_reg <= accept ? plan.count : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_plan_reg <= plan;
        end
    end

    // A chunk starting at the current byte takes the forwarded count, as its slot is written that same cycle
    ptc_pkg::result_t res0;
    ptc_pkg::result_t res1;

    always_comb begin
        res0.start  = s1_plan_reg.desc0.start;
        res0.length = s1_plan_reg.desc0.length;
        res0.fin    = s1_plan_reg.desc0.fin;
        res0.last   = s1_plan_reg.desc0.last;
        res0.line   = first_line_reg +
                      (s1_plan_reg.fwd0 ? s1_plan_reg.fwd_line : rd_data0);
        res1.start  = s1_plan_reg.desc1.start;
        res1.length = s1_plan_reg.desc1.length;
        res1.fin    = s1_plan_reg.desc1.fin;
        res1.last   = s1_plan_reg.desc1.last;
        res1.line   = first_line_reg +
                      (s1_plan_reg.fwd1 ? s1_plan_reg.fwd_line : rd_data1);
    end

    ptc_pkg::result_t out_data;
    logic [2:0]       fill;
    logic             pop;

    assign pop = m_axis_tvalid && m_axis_tready;

    ptc_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (s1_count_reg),
        .push_data0 (res0),
        .push_data1 (res1),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_data),
        .fill       (fill)
    );

    // Room for two more results beyond what is queued or in flight
    assign s_axis_tready = ({1'b0, fill} + {2'd0, s1_count_reg}) <= 4'd2;

    assign m_axis_tdata    = {3'd0, out_data.line, out_data.length, out_data.start};
    assign m_axis_tuser[0] = out_data.fin;
    assign m_axis_tlast    = out_data.last;

endmodule

`default_nettype wire

// ===== design/ptc_line_ram.sv =====
// ----------------------------------------------------------------------------
// ptc_line_ram
// Ring of newline counts, one per recent byte; one write, two registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptc_line_ram #(
    parameter int unsigned DEPTH  = 8192,
    parameter int unsigned ADDR_W = 13
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr0,
    input  wire logic [ADDR_W-1:0] rd_addr1,
    output logic      [31:0]       rd_data0,
    output logic      [31:0]       rd_data1
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

`default_nettype wire

// ===== design/ptc_tracker.sv =====
// ----------------------------------------------------------------------------
// ptc_tracker
// Per-byte document state: chunk offset, pending blank line, newline count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptc_tracker #(
    parameter int unsigned DEPTH     = 8192,
    parameter int unsigned ADDR_W    = 13,
    parameter int unsigned MIN_SPLIT = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_document,
    input  wire logic [12:0]       window_bytes,
    input  wire logic [12:0]       overlap_bytes,
    input  wire logic              paragraph_mode,
    output ptc_pkg::plan_t         plan,
    output logic      [ADDR_W-1:0] wr_addr,
    output logic      [31:0]       wr_data,
    output logic      [ADDR_W-1:0] rd_addr0,
    output logic      [ADDR_W-1:0] rd_addr1
);

    localparam logic [12:0] WIN_MAX = 13'((ptc_pkg::MAX_WINDOW < DEPTH - 1) ?
                                          ptc_pkg::MAX_WINDOW : DEPTH - 1);

    // off_reg is byte position minus chunk start; dp_reg is blank-line start
    // minus chunk start (wraps like the offsets themselves).
    logic [12:0]       off_reg,   off_next;
    logic [31:0]       start_reg, start_next;
    logic [31:0]       nl_reg,    nl_next;
    logic              prev_nl_reg, prev_nl_next;
    logic              seen_reg,  seen_next;
    logic [31:0]       dp_reg,    dp_next;
    logic [ADDR_W-1:0] slot_reg,  slot_next;

    logic [12:0] w_used;
    logic        is_nl;
    logic        seen_cur;
    logic [31:0] dp_cur;
    logic        split_ok;
    logic        do_chunk;
    logic [12:0] endoff;
    logic        fin;
    logic [12:0] step;
    logic [12:0] off_after;
    logic [31:0] start_step;

    always_comb begin
        if (window_bytes == 13'd0) begin
            w_used = 13'd1;
        end else if (window_bytes > WIN_MAX) begin
            w_used = WIN_MAX;
        end else begin
            w_used = window_bytes;
        end
    end

    always_comb begin
        is_nl    = (data_byte == ptc_pkg::NEWLINE_CODE);
        seen_cur = seen_reg;
        dp_cur   = dp_reg;
        if (is_nl && prev_nl_reg) begin
            seen_cur = 1'b1;
            dp_cur   = {19'd0, off_reg} - 32'd1;
        end

        split_ok = paragraph_mode && seen_cur && (dp_cur[31:13] == 19'd0) &&
                   (dp_cur[12:0] < w_used) && (dp_cur >= 32'(MIN_SPLIT));
        do_chunk = (off_reg >= w_used);
        endoff   = split_ok ? (dp_cur[12:0] + 13'd2) : w_used;
        fin      = end_of_document && (endoff == off_reg + 13'd1);
        step     = (overlap_bytes < endoff) ? (endoff - overlap_bytes) : 13'd1;
        off_after  = off_reg - step;
        start_step = start_reg + {19'd0, step};
    end

    always_comb begin
        plan          = '0;
        plan.fwd_line = nl_reg;
        plan.fwd0     = (off_reg == 13'd0);
        plan.fwd1     = (off_after == 13'd0);
        plan.desc0.start = start_reg;
        plan.desc1.start = start_step;
        plan.desc1.length = off_after + 13'd1;
        plan.desc1.fin    = 1'b1;
        plan.desc1.last   = 1'b1;
        if (do_chunk) begin
            plan.desc0.length = endoff;
            plan.desc0.fin    = fin;
            plan.desc0.last   = !end_of_document || fin;
            plan.count = (end_of_document && !fin) ? 2'd2 : 2'd1;
        end else begin
            plan.desc0.length = off_reg + 13'd1;
            plan.desc0.fin    = 1'b1;
            plan.desc0.last   = 1'b1;
            plan.count = end_of_document ? 2'd1 : 2'd0;
        end
    end

    assign wr_addr  = slot_reg;
    assign wr_data  = nl_reg;
    assign rd_addr0 = start_reg[ADDR_W-1:0];
    assign rd_addr1 = start_step[ADDR_W-1:0];

    always_comb begin
        off_next     = off_reg + 13'd1;
        start_next   = start_reg;
        nl_next      = nl_reg + {31'd0, is_nl};
        prev_nl_next = is_nl;
        seen_next    = seen_cur;
        dp_next      = dp_cur;
        slot_next    = slot_reg + ADDR_W'(1);
        if (do_chunk && !fin) begin
            off_next   = off_after + 13'd1;
            start_next = start_step;
            dp_next    = dp_cur - {19'd0, step};
            if (seen_cur && (dp_cur < {19'd0, step})) begin
                seen_next = 1'b0;
            end
        end
        if (end_of_document) begin
            off_next     = '0;
            start_next   = '0;
            nl_next      = '0;
            prev_nl_next = 1'b0;
            seen_next    = 1'b0;
            dp_next      = '0;
            slot_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg     <= '0;
            start_reg   <= '0;
            nl_reg      <= '0;
            prev_nl_reg <= 1'b0;
            seen_reg    <= 1'b0;
            dp_reg      <= '0;
            slot_reg    <= '0;
        end else if (accept) begin
            off_reg     <= off_next;
            start_reg   <= start_next;
            nl_reg      <= nl_next;
            prev_nl_reg <= prev_nl_next;
            seen_reg    <= seen_next;
            dp_reg      <= dp_next;
            slot_reg    <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ptc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ptc_out_fifo
// Four-entry result queue; takes up to two results per cycle, gives one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptc_out_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        push_count,
    input  ptc_pkg::result_t       push_data0,
    input  ptc_pkg::result_t       push_data1,
    input  wire logic              pop,
    output logic                   out_valid,
    output ptc_pkg::result_t       out_data,
    output logic      [2:0]        fill
);

    ptc_pkg::result_t entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg,   fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        fill_next   = fill_reg + {1'b0, push_count} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= push_data1;
        end
    end

    assign out_valid = (fill_reg != 3'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign fill      = fill_reg;

endmodule

`default_nettype wire

// ===== design/ptc_checker.sv =====
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the chunker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ptc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic stalled;
    assign stalled = m_axis_tvalid && !m_axis_tready;

    // the final chunk always closes the run of its byte
    `PTC_ASSERT_IMP(a_final_is_last, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    // chunks are never empty
    `PTC_ASSERT_IMP(a_length_nonzero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[44:32] != 13'd0)
    `PTC_ASSERT_NXT(a_valid_holds, aclk, aresetn, stalled, m_axis_tvalid)
    `PTC_ASSERT_NXT(a_data_holds, aclk, aresetn, stalled, $stable(m_axis_tdata))

endmodule

bind paragraph_aware_text_chunker ptc_checker u_ptc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams documents byte by byte into the text chunker and checks every chunk
// descriptor against an in-bench model of the chunking rules or a typed table
// row. Directed rows come first, then randomly configured documents. Both stream
// sides idle at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RING_DEPTH   = 8192;
    localparam int unsigned MIN_SPLIT    = 64;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          RANDOM_BYTES = 900;
    localparam int          MAX_REPORTS  = 10;
    localparam int          IDLE_PCT     = 9;
    localparam longint      LIMIT_NS     = 6_000_000;

    typedef enum logic [0:0] {ROW_BYTE, ROW_CFG} row_kind_t;

    // One row of the directed table; exp is used only when typed is set and
    // applies to the last byte of the row.
    typedef struct packed {
        row_kind_t        kind;
        logic [1:0]       idx;
        logic [31:0]      val;
        logic [7:0]       data;
        logic [15:0]      rep;
        logic             eod;
        logic             typed;
        ptc_pkg::result_t exp;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 32;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        // after reset: single-byte documents, then a three-byte one
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h41, 16'd1, 1'b1, 1'b1,
          '{32'd0, 13'd1, 32'd1, 1'b1, 1'b1}},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'hFF, 16'd1, 1'b1, 1'b1,
          '{32'd0, 13'd1, 32'd1, 1'b1, 1'b1}},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd1, 1'b1, 1'b1,
          '{32'd0, 13'd1, 32'd1, 1'b1, 1'b1}},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h00, 16'd1, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd1, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd1, 1'b1, 1'b1,
          '{32'd0, 13'd3, 32'd1, 1'b1, 1'b1}},
        // smallest window, zero overlap, line number wraps
        '{ROW_CFG,  ptc_pkg::REG_FIRSTLINE, 32'hFFFF_FFFF, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_WINDOW,    32'd1,         8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_OVERLAP,   32'd0,         8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd3, 1'b1, 1'b0, '0},
        // window below range, overlap far above chunk length
        '{ROW_CFG,  ptc_pkg::REG_WINDOW,    32'd0,    8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_OVERLAP,   32'd8191, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h55, 16'd4, 1'b1, 1'b0, '0},
        // window above range, fixed-length mode, line base zero
        '{ROW_CFG,  ptc_pkg::REG_WINDOW,    32'd8191, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_OVERLAP,   32'd4096, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_PARAGRAPH, 32'd0,    8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_FIRSTLINE, 32'd0,    8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'hAA, 16'd5, 1'b1, 1'b1,
          '{32'd0, 13'd5, 32'd0, 1'b1, 1'b1}},
        // paragraph split past the minimum offset
        '{ROW_CFG,  ptc_pkg::REG_WINDOW,    32'd100, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_OVERLAP,   32'd10,  8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_PARAGRAPH, 32'd1,   8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_FIRSTLINE, 32'd7,   8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h78,                 16'd70, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd2,  1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h79,                 16'd40, 1'b1, 1'b0, '0},
        // blank line starting on the last window byte
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h78,                 16'd99, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd2,  1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h79,                 16'd5,  1'b1, 1'b0, '0},
        // window shrunk in the middle of a document
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, 8'h20,                 16'd50, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_WINDOW,    32'd10, 8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  ptc_pkg::REG_OVERLAP,   32'd3,  8'h00, 16'd0, 1'b0, 1'b0, '0},
        '{ROW_BYTE, ptc_pkg::REG_WINDOW, 32'd0, ptc_pkg::NEWLINE_CODE, 16'd6,  1'b1, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = ptc_pkg::REG_WINDOW;
    logic [31:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;  // [31:0] chunk_start, [44:32] chunk_length,
                                // [76:45] chunk_line, [79:77] zero
    logic [0:0]  m_axis_tuser;  // [0] final_chunk
    logic        m_axis_tlast;  // run_last

    paragraph_aware_text_chunker #(
        .WINDOW_DEPTH     (RING_DEPTH),
        .MIN_SPLIT_OFFSET (MIN_SPLIT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Chunking model
    // ------------------------------------------------------------------
    logic [12:0] reg_window;
    logic [12:0] reg_overlap;
    logic        reg_para;
    logic [31:0] reg_first;

    logic [31:0] doc_pos;
    logic [31:0] chunk_origin;
    logic [31:0] nl_total;
    logic        prev_nl;
    logic        pair_seen;
    logic [31:0] pair_start;
    logic [31:0] line_ring [RING_DEPTH];
    int unsigned ring_slot;

    ptc_pkg::result_t step_out [2];
    ptc_pkg::result_t chunk_queue [$];

    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d chunks still outstanding", chunk_queue.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic void enqueue_chunk(ptc_pkg::result_t r);
        chunk_queue = {chunk_queue, r};
    endfunction

    function automatic void clear_document();
        doc_pos      = '0;
        chunk_origin = '0;
        nl_total     = '0;
        prev_nl      = 1'b0;
        pair_seen    = 1'b0;
        pair_start   = '0;
        ring_slot    = 0;
    endfunction

    function automatic void apply_config(logic [1:0] idx, logic [31:0] val);
        case (idx)
            ptc_pkg::REG_WINDOW:    reg_window  = val[12:0];
            ptc_pkg::REG_OVERLAP:   reg_overlap = val[12:0];
            ptc_pkg::REG_PARAGRAPH: reg_para    = val[0];
            ptc_pkg::REG_FIRSTLINE: reg_first   = val;
            default: ;
        endcase
    endfunction

    function automatic int unsigned eff_window();
        int unsigned w;
        w = reg_window;
        if (w < 1) w = 1;
        if (w > ptc_pkg::MAX_WINDOW) w = ptc_pkg::MAX_WINDOW;
        if (w > RING_DEPTH - 1) w = RING_DEPTH - 1;
        return w;
    endfunction

    // line number of the byte 'back' positions before the current one
    function automatic logic [31:0] line_at(logic [31:0] back);
        int unsigned idx;
        idx = (ring_slot + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH;
        return reg_first + line_ring[idx];
    endfunction

    function automatic ptc_pkg::result_t make_chunk(logic [31:0] start, logic [31:0] len,
                                                    logic [31:0] line, logic fin,
                                                    logic last);
        ptc_pkg::result_t r;
        r.start  = start;
        r.length = len[12:0];
        r.line   = line;
        r.fin    = fin;
        r.last   = last;
        return r;
    endfunction

    // Advances the model by one byte; results land in step_out, count returned.
    function automatic int predict_chunks(logic [7:0] b, logic eod);
        logic [31:0] p, w, off, endoff, dp, stp;
        logic        fin;
        int          n;
        p = doc_pos;
        w = eff_window();
        n = 0;
        line_ring[ring_slot] = nl_total;
        if (b == ptc_pkg::NEWLINE_CODE) begin
            if (prev_nl) begin
                pair_start = p - 32'd1;
                pair_seen  = 1'b1;
            end
            nl_total = nl_total + 32'd1;
            prev_nl  = 1'b1;
        end else begin
            prev_nl = 1'b0;
        end

        off = p - chunk_origin;
        if (off >= w) begin
            endoff = w;
            if (reg_para && pair_seen) begin
                dp = pair_start - chunk_origin;
                if (dp >= MIN_SPLIT && dp < w) endoff = dp + 32'd2;
            end
            fin = eod && (endoff == off + 32'd1);
            step_out[n] = make_chunk(chunk_origin, endoff, line_at(off), fin, !eod || fin);
            n++;
            if (!fin) begin
                stp = (reg_overlap < endoff) ? endoff - reg_overlap : 32'd1;
                // a blank line left behind by the new start no longer counts
                if (pair_seen && (pair_start - chunk_origin) < stp) pair_seen = 1'b0;
                chunk_origin = chunk_origin + stp;
                if (eod) begin
                    off = p - chunk_origin;
                    step_out[n] = make_chunk(chunk_origin, off + 32'd1, line_at(off),
                                             1'b1, 1'b1);
                    n++;
                end
            end
        end else if (eod) begin
            step_out[n] = make_chunk(chunk_origin, off + 32'd1, line_at(off), 1'b1, 1'b1);
            n++;
        end

        if (eod) begin
            clear_document();
        end else begin
            doc_pos   = doc_pos + 32'd1;
            ring_slot = (ring_slot + 1) % RING_DEPTH;
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Stream sides
    // ------------------------------------------------------------------
    bit calm = 1'b0;          // no idling on either side while set
    int hold_req = 0;
    int hold_served = 0;
    int fail_count = 0;
    int chunks_checked = 0;
    int bytes_sent = 0;
    int docs_sent = 0;
    int cfg_writes = 0;

    task automatic note_failure(string what, bit has_want, ptc_pkg::result_t want,
                                ptc_pkg::result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            if (has_want)
                $display("%s: expected start=%0d len=%0d line=%0d fin=%0b last=%0b",
                         what, want.start, want.length, want.line, want.fin, want.last);
            $display("%s: actual   start=%0d len=%0d line=%0d fin=%0b last=%0b",
                     what, got.start, got.length, got.line, got.fin, got.last);
        end
    endtask

    // Output receiver; the long hold-off is counted here.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_req) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (calm) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    ptc_pkg::result_t got_chunk, want_chunk;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_chunk.start  = m_axis_tdata[31:0];
            got_chunk.length = m_axis_tdata[44:32];
            got_chunk.line   = m_axis_tdata[76:45];
            got_chunk.fin    = m_axis_tuser[0];
            got_chunk.last   = m_axis_tlast;
            chunks_checked++;
            if (chunk_queue.size() == 0) begin
                note_failure("unexpected chunk", 1'b0, '0, got_chunk);
            end else begin
                want_chunk = chunk_queue.pop_front();
                if (got_chunk.start  !== want_chunk.start  ||
                    got_chunk.length !== want_chunk.length ||
                    got_chunk.line   !== want_chunk.line   ||
                    got_chunk.fin    !== want_chunk.fin    ||
                    got_chunk.last   !== want_chunk.last)
                    note_failure("chunk mismatch", 1'b1, want_chunk, got_chunk);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic eod, logic typed,
                             ptc_pkg::result_t typed_exp);
        int n;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        do @(posedge aclk); while (!s_axis_tready);
        n = predict_chunks(b, eod);
        if (typed) begin
            enqueue_chunk(typed_exp);
        end else begin
            for (int i = 0; i < n; i++) enqueue_chunk(step_out[i]);
        end
        bytes_sent++;
        if (eod) docs_sent++;
    endtask

    // Stop the input and let every chunk and any byte in flight drain.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (chunk_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_config(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
    endtask

    task automatic pick_config();
        int unsigned w, ov, r;
        r = $urandom_range(0, 99);
        if (r < 55)      w = $urandom_range(1, 60);
        else if (r < 85) w = $urandom_range(65, 300);
        else if (r < 91) w = ptc_pkg::MAX_WINDOW;
        else if (r < 96) w = $urandom_range(4097, 8191);
        else             w = 0;
        r = $urandom_range(0, 99);
        if (r < 25)      ov = 0;
        else if (r < 70) ov = $urandom_range(0, w / 2);
        else if (r < 85) ov = $urandom_range(w, w + 20);
        else             ov = $urandom_range(0, 8191);
        if (ov > 8191) ov = 8191;
        cfg_write(ptc_pkg::REG_WINDOW, w);
        cfg_write(ptc_pkg::REG_OVERLAP, ov);
        cfg_write(ptc_pkg::REG_PARAGRAPH, ($urandom_range(0, 99) < 70));
        r = $urandom_range(0, 99);
        if (r < 50)      cfg_write(ptc_pkg::REG_FIRSTLINE, $urandom);
        else if (r < 75) cfg_write(ptc_pkg::REG_FIRSTLINE,
                                   32'hFFFF_FFFF - $urandom_range(0, 20));
        else             cfg_write(ptc_pkg::REG_FIRSTLINE, $urandom_range(0, 100));
    endtask

    // Text with paragraph breaks spread around the window size, or raw noise.
    task automatic send_document(int len, bit noise);
        int unsigned span, gap, r;
        int          nl_burst;
        logic [7:0]  b;
        span = eff_window();
        gap = $urandom_range(2, span + 8);
        nl_burst = 0;
        for (int i = 0; i < len; i++) begin
            if (noise) begin
                b = $urandom_range(0, 255);
            end else if (nl_burst > 0) begin
                b = ptc_pkg::NEWLINE_CODE;
                nl_burst--;
            end else if (gap == 0) begin
                b = ptc_pkg::NEWLINE_CODE;
                nl_burst = 1;
                gap = $urandom_range(2, span + 8);
            end else begin
                gap--;
                r = $urandom_range(0, 99);
                if (r < 5)      b = ptc_pkg::NEWLINE_CODE;
                else if (r < 9) b = $urandom_range(0, 255);
                else            b = $urandom_range(32, 126);
            end
            send_byte(b, (i == len - 1), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    stim_row_t   row;
    int          directed_bytes;
    int          doc_index;
    int          doc_len;
    int unsigned span_now;
    bit          last_one;

    initial begin
        reg_window  = ptc_pkg::WINDOW_RESET;
        reg_overlap = ptc_pkg::OVERLAP_RESET;
        reg_para    = ptc_pkg::PARAGRAPH_RESET;
        reg_first   = ptc_pkg::FIRSTLINE_RESET;
        clear_document();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                wait_quiet();
                cfg_write(row.idx, row.val);
            end else begin
                for (int k = 0; k < row.rep; k++) begin
                    last_one = (k == row.rep - 1);
                    send_byte(row.data, row.eod && last_one, row.typed && last_one, row.exp);
                end
            end
        end
        directed_bytes = bytes_sent;

        doc_index = 0;
        while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
            doc_index++;
            wait_quiet();
            calm = (doc_index >= 8 && doc_index <= 11);
            if (doc_index == 5) begin
                // from the third byte on, every byte closes a chunk; output stalls so the input backs up
                cfg_write(ptc_pkg::REG_WINDOW, 2);
                cfg_write(ptc_pkg::REG_OVERLAP, 1);
                hold_req++;
                send_document(200, 1'b0);
            end else begin
                if ($urandom_range(0, 3) != 0) pick_config();
                span_now = eff_window();
                if (span_now > 300) doc_len = $urandom_range(1, 60);
                else doc_len = $urandom_range(1, 2 * span_now + 40);
                if (doc_len > 400) doc_len = 400;
                send_document(doc_len, ($urandom_range(0, 99) < 15));
            end
        end
        calm = 1'b0;

        wait_quiet();
        if (chunk_queue.size() != 0) fail_count += chunk_queue.size();
        $display("run covered %0d documents, %0d bytes, %0d chunk descriptors checked",
                 docs_sent, bytes_sent, chunks_checked);
        $display("%0d register writes incl. range extremes; one long output hold-off",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ptc_pkg.sv
design/ptc_line_ram.sv
design/ptc_tracker.sv
design/ptc_out_fifo.sv
design/paragraph_aware_text_chunker.sv
design/ptc_checker.sv
dv/tb_top.sv
